// ===== rtl/core/prqs_pkg.sv =====
// ============================================================================
// prqs_pkg
// Shared types and constants of the priority ready queue scheduler.
// ============================================================================
package prqs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 8;
    localparam int PRI_W       = 4;
    localparam int COUNT_W     = 5;
    localparam int STATUS_W    = 2;
    localparam int CMD_W       = 2;

    localparam logic [CMD_W-1:0] CMD_CREATE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_YIELD     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TERMINATE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NORUN = 2'd2;

    localparam logic [ID_W-1:0]  MAIN_ID       = 8'd0;
    localparam logic [PRI_W-1:0] MAIN_PRIORITY = 4'd1;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_SHIFT  = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [ID_W-1:0]   id;
        logic [PRI_W-1:0]  pri;
    } cell_cmd_t;

endpackage

// ===== rtl/core/prqs_cell.sv =====
// ============================================================================
// prqs_cell
// One slot of the sorted ready queue; holds an id and its priority.
// ============================================================================
module prqs_cell (
    input  logic                        clk,
    input  prqs_pkg::cell_cmd_t         cmd,
    input  logic                        occupied,
    input  logic                        prev_le,
    input  logic [prqs_pkg::ID_W-1:0]   prev_id,
    input  logic [prqs_pkg::PRI_W-1:0]  prev_pri,
    input  logic [prqs_pkg::ID_W-1:0]   next_id,
    input  logic [prqs_pkg::PRI_W-1:0]  next_pri,
    output logic                        le,
    output logic [prqs_pkg::ID_W-1:0]   id,
    output logic [prqs_pkg::PRI_W-1:0]  pri
);

    logic [prqs_pkg::ID_W-1:0]  id_reg;
    logic [prqs_pkg::ID_W-1:0]  id_next;
    logic [prqs_pkg::PRI_W-1:0] pri_reg;
    logic [prqs_pkg::PRI_W-1:0] pri_next;

    // An occupied slot whose priority is not above the new one keeps its place.
    assign le  = occupied && (pri_reg <= cmd.pri);
    assign id  = id_reg;
    assign pri = pri_reg;

    always_comb
    begin
        id_next  = id_reg;
        pri_next = pri_reg;
        unique case (cmd.op)
            prqs_pkg::OP_INSERT:
            begin
                if (!le)
                begin
                    if (prev_le)
                    begin
                        id_next  = cmd.id;
                        pri_next = cmd.pri;
                    end
                    else
                    begin
                        id_next  = prev_id;
                        pri_next = prev_pri;
                    end
                end
            end
            prqs_pkg::OP_SHIFT:
            begin
                id_next  = next_id;
                pri_next = next_pri;
            end
            default:
            begin
                id_next  = id_reg;
                pri_next = pri_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        pri_reg <= pri_next;
    end

endmodule

// ===== rtl/core/priority_ready_queue_scheduler_top.sv =====
// ============================================================================
// priority_ready_queue_scheduler_top
// Running thread plus a priority-sorted ready queue built as a row of cells.
// ============================================================================
// Create, terminate, failed and unused commands, and a yield on an empty
// queue, have their result registered at the accepting edge. A yield that
// swaps threads passes through ST_REQUEUE: the queue shifts out its head,
// then the old thread is inserted. One command is in flight at a time.
// Reset starts the main thread (id 0, priority 1) with an empty queue.
module priority_ready_queue_scheduler_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // create_id[7:0], priority_req[11:8], zero fill
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // running_id[7:0], running_valid[8],
                                   // ready_count[13:9], status[15:14]
);

    localparam int DEPTH = prqs_pkg::QUEUE_DEPTH;
    localparam int FW    = prqs_pkg::FILL_W;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'b01,
        ST_REQUEUE = 2'b10
    } state_t;

    state_t                      state_reg, state_next;
    logic [FW-1:0]               fill_reg, fill_next;
    logic [prqs_pkg::ID_W-1:0]   run_id_reg, run_id_next;
    logic [prqs_pkg::PRI_W-1:0]  run_pri_reg, run_pri_next;
    logic                        run_valid_reg, run_valid_next;
    logic [prqs_pkg::ID_W-1:0]   pend_id_reg, pend_id_next;
    logic [prqs_pkg::PRI_W-1:0]  pend_pri_reg, pend_pri_next;
    logic                        out_valid_reg;
    logic [15:0]                 out_data_reg;

    prqs_pkg::cell_cmd_t             cell_cmd;
    logic [prqs_pkg::STATUS_W-1:0]   status;
    logic                            res_load;
    logic                            accept;
    logic [FW+prqs_pkg::COUNT_W-1:0] count_ext;
    logic [prqs_pkg::ID_W-1:0]       shown_id;

    logic [prqs_pkg::ID_W-1:0]  cell_id  [DEPTH];
    logic [prqs_pkg::PRI_W-1:0] cell_pri [DEPTH];
    logic                       cell_le  [DEPTH];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic                       occ;
            logic                       p_le;
            logic [prqs_pkg::ID_W-1:0]  p_id;
            logic [prqs_pkg::PRI_W-1:0] p_pri;
            logic [prqs_pkg::ID_W-1:0]  n_id;
            logic [prqs_pkg::PRI_W-1:0] n_pri;

            assign occ = fill_reg > FW'(g);

            if (g == 0)
            begin : g_first
                assign p_le  = 1'b0;
                assign p_id  = cell_cmd.id;
                assign p_pri = cell_cmd.pri;
            end
            else
            begin : g_mid
                assign p_le  = cell_le[g-1];
                assign p_id  = cell_id[g-1];
                assign p_pri = cell_pri[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign n_id  = cell_id[g];
                assign n_pri = cell_pri[g];
            end
            else
            begin : g_inner
                assign n_id  = cell_id[g+1];
                assign n_pri = cell_pri[g+1];
            end

            prqs_cell u_cell (
                .clk      (clk),
                .cmd      (cell_cmd),
                .occupied (occ),
                .prev_le  (p_le),
                .prev_id  (p_id),
                .prev_pri (p_pri),
                .next_id  (n_id),
                .next_pri (n_pri),
                .le       (cell_le[g]),
                .id       (cell_id[g]),
                .pri      (cell_pri[g])
            );
        end
    endgenerate

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        run_id_next    = run_id_reg;
        run_pri_next   = run_pri_reg;
        run_valid_next = run_valid_reg;
        pend_id_next   = pend_id_reg;
        pend_pri_next  = pend_pri_reg;
        status         = prqs_pkg::STATUS_OK;
        res_load       = 1'b0;
        cell_cmd.op    = prqs_pkg::OP_HOLD;
        cell_cmd.id    = s_tdata[7:0];
        cell_cmd.pri   = s_tdata[11:8];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_load = 1'b1;
                    unique case (s_tuser)
                        prqs_pkg::CMD_CREATE:
                        begin
                            if (fill_reg == FW'(DEPTH))
                            begin
                                status = prqs_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                cell_cmd.op = prqs_pkg::OP_INSERT;
                                fill_next   = fill_reg + 1'b1;
                            end
                        end
                        prqs_pkg::CMD_YIELD:
                        begin
                            if (!run_valid_reg)
                            begin
                                status = prqs_pkg::STATUS_NORUN;
                            end
                            else if (fill_reg != '0)
                            begin
                                cell_cmd.op   = prqs_pkg::OP_SHIFT;
                                fill_next     = fill_reg - 1'b1;
                                run_id_next   = cell_id[0];
                                run_pri_next  = cell_pri[0];
                                pend_id_next  = run_id_reg;
                                pend_pri_next = run_pri_reg;
                                res_load      = 1'b0;
                                state_next    = ST_REQUEUE;
                            end
                        end
                        prqs_pkg::CMD_TERMINATE:
                        begin
                            if (!run_valid_reg)
                            begin
                                status = prqs_pkg::STATUS_NORUN;
                            end
                            else if (fill_reg != '0)
                            begin
                                cell_cmd.op  = prqs_pkg::OP_SHIFT;
                                fill_next    = fill_reg - 1'b1;
                                run_id_next  = cell_id[0];
                                run_pri_next = cell_pri[0];
                            end
                            else
                            begin
                                run_valid_next = 1'b0;
                                run_id_next    = '0;
                                run_pri_next   = '0;
                            end
                        end
                        default:
                        begin
                            status = prqs_pkg::STATUS_OK;
                        end
                    endcase
                end
            end
            ST_REQUEUE:
            begin
                cell_cmd.op  = prqs_pkg::OP_INSERT;
                cell_cmd.id  = pend_id_reg;
                cell_cmd.pri = pend_pri_reg;
                fill_next    = fill_reg + 1'b1;
                res_load     = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign count_ext = (FW + prqs_pkg::COUNT_W)'(fill_next);
    assign shown_id  = run_valid_next ? run_id_next : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            run_id_reg    <= prqs_pkg::MAIN_ID;
            run_pri_reg   <= prqs_pkg::MAIN_PRIORITY;
            run_valid_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            run_id_reg    <= run_id_next;
            run_pri_reg   <= run_pri_next;
            run_valid_reg <= run_valid_next;
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_id_reg  <= pend_id_next;
        pend_pri_reg <= pend_pri_next;
        if (res_load)
        begin
            out_data_reg <= {status, count_ext[prqs_pkg::COUNT_W-1:0],
                             run_valid_next, shown_id};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== test/priority_ready_queue_scheduler_top_tb.sv =====
// ============================================================================
// priority_ready_queue_scheduler_top_tb
// Self-checking testbench for the priority ready queue scheduler.
// ============================================================================
// Commands are queued up front and sent by a clocked driver with random idle
// bursts, while the result side stalls at random. Each accepted command runs
// through a scoreboard model of the running thread and the sorted ready queue.
// Every result beat is compared field by field with the oldest prediction.
// The directed part covers the field extremes, equal priorities, a full
// queue, yield on an empty queue and the unused command. The random part
// fills and drains the queue in phases, and the end of the run retires the
// last thread to reach the no-running-thread cases.
module priority_ready_queue_scheduler_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [prqs_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_CMDS = 950;
    localparam int CALM_TAIL   = 60;

    typedef struct {
        logic [prqs_pkg::CMD_W-1:0] cmd;
        logic [prqs_pkg::ID_W-1:0]  id;
        logic [prqs_pkg::PRI_W-1:0] pri;
        bit                         drain_first;
    } sched_cmd_t;

    typedef struct {
        logic [prqs_pkg::ID_W-1:0]  id;
        logic [prqs_pkg::PRI_W-1:0] pri;
    } thread_t;

    typedef struct {
        logic [prqs_pkg::ID_W-1:0]     running_id;
        logic                          running_valid;
        logic [prqs_pkg::COUNT_W-1:0]  ready_count;
        logic [prqs_pkg::STATUS_W-1:0] status;
    } sched_state_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    sched_cmd_t   pending_cmds[$];
    sched_state_t expected_states[$];
    sched_cmd_t   cmd_on_bus;

    thread_t                    ready_tbl[prqs_pkg::QUEUE_DEPTH];
    int                         ready_fill;
    logic [prqs_pkg::ID_W-1:0]  run_id;
    logic [prqs_pkg::PRI_W-1:0] run_pri;
    bit                         run_alive;

    int  error_count = 0;
    int  beats_checked = 0;
    int  n_create = 0;
    int  n_swap = 0;
    int  n_retire = 0;
    int  n_full = 0;
    int  n_norun = 0;
    int  send_gap = 0;
    int  recv_stall = 0;
    bit  calm;

    priority_ready_queue_scheduler_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    assign calm = (pending_cmds.size() < CALM_TAIL);

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    function automatic void queue_thread(input logic [prqs_pkg::ID_W-1:0] id,
                                         input logic [prqs_pkg::PRI_W-1:0] pri);
        int pos;
        pos = 0;
        while (pos < ready_fill && ready_tbl[pos].pri <= pri)
            pos++;
        for (int i = ready_fill; i > pos; i--)
            ready_tbl[i] = ready_tbl[i-1];
        ready_tbl[pos].id = id;
        ready_tbl[pos].pri = pri;
        ready_fill++;
    endfunction

    function automatic thread_t pop_head();
        thread_t head;
        head = ready_tbl[0];
        for (int i = 1; i < ready_fill; i++)
            ready_tbl[i-1] = ready_tbl[i];
        ready_fill--;
        return head;
    endfunction

    function automatic void schedule_cmd(input sched_cmd_t c);
        sched_state_t nxt;
        thread_t      head;
        nxt.status = prqs_pkg::STATUS_OK;
        case (c.cmd)
            prqs_pkg::CMD_CREATE:
            begin
                if (ready_fill >= prqs_pkg::QUEUE_DEPTH)
                begin
                    nxt.status = prqs_pkg::STATUS_FULL;
                    n_full++;
                end
                else
                begin
                    queue_thread(c.id, c.pri);
                    n_create++;
                end
            end
            prqs_pkg::CMD_YIELD:
            begin
                if (!run_alive)
                begin
                    nxt.status = prqs_pkg::STATUS_NORUN;
                    n_norun++;
                end
                else if (ready_fill > 0)
                begin
                    head = pop_head();
                    queue_thread(run_id, run_pri);
                    run_id = head.id;
                    run_pri = head.pri;
                    n_swap++;
                end
            end
            prqs_pkg::CMD_TERMINATE:
            begin
                if (!run_alive)
                begin
                    nxt.status = prqs_pkg::STATUS_NORUN;
                    n_norun++;
                end
                else
                begin
                    n_retire++;
                    if (ready_fill > 0)
                    begin
                        head = pop_head();
                        run_id = head.id;
                        run_pri = head.pri;
                    end
                    else
                    begin
                        run_alive = 1'b0;
                        run_id = '0;
                        run_pri = '0;
                    end
                end
            end
            default: ;
        endcase
        nxt.running_id = run_alive ? run_id : '0;
        nxt.running_valid = run_alive;
        nxt.ready_count = ready_fill[prqs_pkg::COUNT_W-1:0];
        expected_states.push_back(nxt);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                schedule_cmd(cmd_on_bus);
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_cmds.size() > 0 &&
                         !(pending_cmds[0].drain_first && expected_states.size() > 0))
                begin
                    if (!calm && $urandom_range(0, 11) == 0)
                    begin
                        send_gap = $urandom_range(0, 16);
                        s_tvalid <= 1'b0;
                    end
                    else
                    begin
                        cmd_on_bus = pending_cmds.pop_front();
                        s_tvalid <= 1'b1;
                        s_tdata <= {4'b0, cmd_on_bus.pri, cmd_on_bus.id};
                        s_tuser <= cmd_on_bus.cmd;
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        sched_state_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                beats_checked++;
                if (expected_states.size() == 0)
                begin
                    report_mismatch($sformatf("result beat 0x%04h with nothing expected",
                                              m_tdata));
                end
                else
                begin
                    want = expected_states.pop_front();
                    if (m_tdata[7:0] !== want.running_id)
                        report_mismatch($sformatf("running_id %0d, expected %0d",
                                                  m_tdata[7:0], want.running_id));
                    if (m_tdata[8] !== want.running_valid)
                        report_mismatch($sformatf("running_valid %0b, expected %0b",
                                                  m_tdata[8], want.running_valid));
                    if (m_tdata[13:9] !== want.ready_count)
                        report_mismatch($sformatf("ready_count %0d, expected %0d",
                                                  m_tdata[13:9], want.ready_count));
                    if (m_tdata[15:14] !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_tdata[15:14], want.status));
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                recv_stall = $urandom_range(0, 16);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    int gen_fill = 0;

    task automatic add_cmd(input logic [prqs_pkg::CMD_W-1:0] c,
                           input logic [prqs_pkg::ID_W-1:0] id,
                           input logic [prqs_pkg::PRI_W-1:0] pri, input bit drain_first);
        sched_cmd_t item;
        item.cmd = c;
        item.id = id;
        item.pri = pri;
        item.drain_first = drain_first;
        pending_cmds.push_back(item);
        if (c == prqs_pkg::CMD_CREATE && gen_fill < prqs_pkg::QUEUE_DEPTH)
            gen_fill++;
        else if (c == prqs_pkg::CMD_TERMINATE && gen_fill > 0)
            gen_fill--;
    endtask

    initial
    begin
        int                         n_rand;
        int                         phase;
        int                         seg_len;
        int                         roll;
        bit                         narrow;
        logic [prqs_pkg::CMD_W-1:0] c;
        logic [prqs_pkg::PRI_W-1:0] pri;
        int                         wait_cycles;

        run_id = prqs_pkg::MAIN_ID;
        run_pri = prqs_pkg::MAIN_PRIORITY;
        run_alive = 1'b1;
        ready_fill = 0;

        add_cmd(prqs_pkg::CMD_YIELD, 8'h00, 4'h0, 1'b0);
        add_cmd(CMD_UNUSED, 8'hff, 4'hf, 1'b0);
        add_cmd(prqs_pkg::CMD_CREATE, 8'hff, 4'hf, 1'b0);
        add_cmd(prqs_pkg::CMD_CREATE, 8'h00, 4'h0, 1'b0);
        add_cmd(prqs_pkg::CMD_CREATE, 8'h11, 4'h1, 1'b0);
        add_cmd(prqs_pkg::CMD_CREATE, 8'h12, 4'h1, 1'b0);
        add_cmd(prqs_pkg::CMD_CREATE, 8'h13, 4'h1, 1'b0);
        add_cmd(prqs_pkg::CMD_CREATE, 8'ha5, 4'h8, 1'b0);
        add_cmd(prqs_pkg::CMD_CREATE, 8'h5a, 4'h7, 1'b0);
        add_cmd(prqs_pkg::CMD_CREATE, 8'h80, 4'hf, 1'b0);
        add_cmd(prqs_pkg::CMD_CREATE, 8'h01, 4'h0, 1'b0);
        add_cmd(prqs_pkg::CMD_CREATE, 8'h7f, 4'h8, 1'b0);
        add_cmd(prqs_pkg::CMD_CREATE, 8'hfe, 4'h1, 1'b0);
        add_cmd(prqs_pkg::CMD_CREATE, 8'h33, 4'h4, 1'b0);
        add_cmd(prqs_pkg::CMD_CREATE, 8'hcc, 4'h2, 1'b0);
        add_cmd(prqs_pkg::CMD_CREATE, 8'h55, 4'h4, 1'b0);
        add_cmd(prqs_pkg::CMD_CREATE, 8'haa, 4'he, 1'b0);
        add_cmd(prqs_pkg::CMD_CREATE, 8'h0f, 4'h3, 1'b0);
        add_cmd(prqs_pkg::CMD_CREATE, 8'hf0, 4'h9, 1'b0);
        add_cmd(prqs_pkg::CMD_YIELD, 8'h00, 4'h0, 1'b0);
        add_cmd(prqs_pkg::CMD_TERMINATE, 8'h00, 4'h0, 1'b0);
        add_cmd(prqs_pkg::CMD_YIELD, 8'h00, 4'h0, 1'b0);
        add_cmd(prqs_pkg::CMD_TERMINATE, 8'h00, 4'h0, 1'b0);

        n_rand = 0;
        while (n_rand < RANDOM_CMDS)
        begin
            phase = $urandom_range(0, 2);
            seg_len = $urandom_range(4, 40);
            narrow = 1'($urandom_range(0, 1));
            for (int k = 0; k < seg_len && n_rand < RANDOM_CMDS; k++)
            begin
                roll = $urandom_range(0, 99);
                pri = narrow ? prqs_pkg::PRI_W'($urandom_range(0, 3))
                             : prqs_pkg::PRI_W'($urandom_range(0, 15));
                if (roll < 2)
                    c = CMD_UNUSED;
                else if (roll < (phase == 0 ? 80 : (phase == 1 ? 20 : 45)))
                    c = prqs_pkg::CMD_CREATE;
                else if (roll < (phase == 0 ? 92 : (phase == 1 ? 50 : 75)))
                    c = prqs_pkg::CMD_YIELD;
                else
                    c = prqs_pkg::CMD_TERMINATE;
                if (c == prqs_pkg::CMD_TERMINATE && gen_fill == 0)
                    c = prqs_pkg::CMD_YIELD;
                add_cmd(c, prqs_pkg::ID_W'($urandom_range(0, 255)), pri,
                        n_rand == 0 || $urandom_range(0, 199) == 0);
                n_rand++;
            end
        end

        while (gen_fill > 0)
            add_cmd(prqs_pkg::CMD_TERMINATE, 8'h00, 4'h0, 1'b0);
        add_cmd(prqs_pkg::CMD_TERMINATE, 8'h00, 4'h0, 1'b0);
        add_cmd(prqs_pkg::CMD_YIELD, 8'h00, 4'h0, 1'b0);
        add_cmd(prqs_pkg::CMD_TERMINATE, 8'h00, 4'h0, 1'b0);
        add_cmd(prqs_pkg::CMD_CREATE, 8'h42, 4'h5, 1'b0);
        add_cmd(prqs_pkg::CMD_CREATE, 8'h24, 4'h2, 1'b0);
        add_cmd(prqs_pkg::CMD_YIELD, 8'h00, 4'h0, 1'b0);
        add_cmd(CMD_UNUSED, 8'h00, 4'h0, 1'b0);
        add_cmd(prqs_pkg::CMD_TERMINATE, 8'h00, 4'h0, 1'b0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || s_tvalid)
            @(posedge clk);
        while (expected_states.size() > 0)
            @(posedge clk);
        wait_cycles = 20;
        repeat (wait_cycles) @(posedge clk);

        $display("Checked %0d result beats: %0d creates, %0d thread swaps, %0d terminates.",
                 beats_checked, n_create, n_swap, n_retire);
        $display("Rejected %0d creates on a full queue and %0d commands with no thread.",
                 n_full, n_norun);
        if (error_count == 0)
            $display("priority_ready_queue_scheduler_top test passed");
        else
            $display("priority_ready_queue_scheduler_top test failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d commands unsent and %0d results outstanding.",
                 pending_cmds.size(), expected_states.size());
        $display("priority_ready_queue_scheduler_top test failed");
        $finish;
    end

endmodule
